/* rtl/core/fanlag_pkg.sv */
// Shared types, widths, register indexes and constants for the fan tachometer
// lag/slew filter. No dependencies; the interface file and the filter top import it.
`timescale 1ns / 1ps
`default_nettype none

package fanlag_pkg;

  // Default parameter values.
  localparam int FAN_CHANNELS_DEF       = 8;
  localparam int GAIN_FRACTION_BITS_DEF = 12;

  // Field widths.
  localparam int CH_FIELD_W = 3;
  localparam int RPM_W      = 16;
  localparam int TIME_W     = 32;
  localparam int STEPS_W    = 10;
  localparam int MULT_W     = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_TAU   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MULT  = 3'd5;

  localparam logic [RPM_W-1:0]   MAX_RPM_RST   = 16'd5000;
  localparam logic [RPM_W-1:0]   LAG_TAU_RST   = 16'd1000;
  localparam logic [RPM_W-1:0]   MAX_SLEW_RST  = 16'd1250;
  localparam logic [RPM_W-1:0]   STOP_THR_RST  = 16'd50;
  localparam logic [STEPS_W-1:0] STEPS_RST     = 10'd0;
  localparam logic [MULT_W-1:0]  RAW_MULT_RST  = 8'd100;

  // Timing and threshold constants.
  localparam logic [TIME_W-1:0] STALE_GAP_MS    = 32'd5000;
  localparam logic [TIME_W-1:0] MIN_GAP_MS      = 32'd100;
  localparam logic [RPM_W-1:0]  THRESHOLD_FLOOR = 16'd10;

  // A gap that reaches the lag path is at most 5000 ms, which fits 13 bits.
  localparam int DT_W        = 13;
  localparam int ALPHA_DEN_W = RPM_W + 1;
  localparam int DELTA_W     = RPM_W + 1;
  localparam int CONV_W      = 2 * RPM_W;

  // Slew limit: floor(slew * dt / 1000) through a reciprocal multiply.
  // The numerator stays below 2^29; with a shift of 29 + 10 the rounded-up
  // reciprocal gives the exact quotient for every such numerator.
  localparam int LIM_NUM_W    = RPM_W + DT_W;
  localparam int RECIP_W      = 30;
  localparam int RECIP_SHIFT  = 39;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 30'd549755814;
  localparam int LIM_FULL_W   = LIM_NUM_W + RECIP_W;
  localparam int LIM_W        = 20;
  localparam int STEP_W       = LIM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_EVAL,
    S_MUL,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    ACT_ZERO,
    ACT_JUMP,
    ACT_HOLD,
    ACT_TIME,
    ACT_LAG
  } act_t;

endpackage

`default_nettype wire

/* rtl/core/fanlag_if.sv */
// Request channels of the fan filter: the reading channel and the result channel.
// Depends on fanlag_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fanlag_in_if
  import fanlag_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] fan_index;
  logic [RPM_W-1:0]      raw_reading;
  logic [TIME_W-1:0]     time_ms;

  modport source (output valid, output fan_index, output raw_reading, output time_ms,
                  input ready);
  modport sink   (input valid, input fan_index, input raw_reading, input time_ms,
                  output ready);
endinterface

interface fanlag_out_if
  import fanlag_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [RPM_W-1:0]      filtered_rpm;
  logic [CH_FIELD_W-1:0] fan_index_echo;

  modport source (output valid, output filtered_rpm, output fan_index_echo, input ready);
  modport sink   (input valid, input filtered_rpm, input fan_index_echo, output ready);
endinterface

`default_nettype wire

/* rtl/core/fanlag_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fanlag_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fanlag_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; the quotient holds once busy falls until the next start.
`timescale 1ns / 1ps
`default_nettype none

module fanlag_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // The partial remainder shifted up with the next numerator bit.
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fan_tach_lag_slew_filter.sv */
// Fan tachometer filter top: per-channel state RAM, conversion and lag sequencer.
// Depends on fanlag_pkg, fanlag_if, fanlag_ram and fanlag_div.
//
//   port      dir   kind        payload
//   reading   in    valid/ready fan_index, raw_reading, time_ms
//   result    out   valid/ready filtered_rpm, fan_index_echo
//   cfg_*     in    write only  cfg_index selects, cfg_data written
//
// After a request is accepted the sequencer runs a RAM read with the conversion
// multiply, a divider start, a wait while the 32-step conversion divider runs
// (the gain divider runs beside it), then evaluate, lag multiply and write-back;
// an out-of-range fan index goes straight to write-back. A new request is taken
// only in the idle state after write-back. Reset is synchronous; it clears the
// sequencer, the result valid flag and the per-channel warm flags and loads the
// configuration defaults. The state RAM is not cleared: what a cold channel reads
// from it is never used. A stalled result only holds the final write-back step.
`timescale 1ns / 1ps
`default_nettype none

module fan_tach_lag_slew_filter
  import fanlag_pkg::*;
#(
  parameter int FAN_CHANNELS       = FAN_CHANNELS_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fanlag_in_if.sink             reading,
  fanlag_out_if.source          result
);

  localparam int CH_W        = (FAN_CHANNELS > 1) ? $clog2(FAN_CHANNELS) : 1;
  localparam logic [4:0] CH_COUNT = 5'(FAN_CHANNELS);
  localparam int G           = GAIN_FRACTION_BITS;
  localparam int ALPHA_NUM_W = DT_W + G;
  localparam int ALPHA_W     = G + 1;
  localparam int PROD_W      = DELTA_W + ALPHA_W + 1;
  localparam int MEM_W       = RPM_W + TIME_W;
  localparam logic signed [STEP_W-1:0] STEP_ONE       = STEP_W'(1);
  localparam logic signed [STEP_W-1:0] STEP_MINUS_ONE = -STEP_ONE;

  // Configuration registers.
  logic [RPM_W-1:0]   max_rpm;
  logic [RPM_W-1:0]   lag_tau;
  logic [RPM_W-1:0]   max_slew;
  logic [RPM_W-1:0]   stop_thr;
  logic [STEPS_W-1:0] steps;
  logic [MULT_W-1:0]  raw_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rpm  <= MAX_RPM_RST;
      lag_tau  <= LAG_TAU_RST;
      max_slew <= MAX_SLEW_RST;
      stop_thr <= STOP_THR_RST;
      steps    <= STEPS_RST;
      raw_mult <= RAW_MULT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RPM:  max_rpm  <= cfg_data;
        REG_LAG_TAU:  lag_tau  <= cfg_data;
        REG_MAX_SLEW: max_slew <= cfg_data;
        REG_STOP_THR: stop_thr <= cfg_data;
        REG_STEPS:    steps    <= cfg_data[STEPS_W-1:0];
        REG_RAW_MULT: raw_mult <= cfg_data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic                     acc;
  logic                     out_free;
  logic                     fin_go;
  logic                     div_start;
  logic                     div_done;

  logic [CH_FIELD_W-1:0]    ch_q;
  logic [CH_W-1:0]          addr;
  logic [RPM_W-1:0]         raw_q;
  logic [TIME_W-1:0]        now_q;
  logic                     oor_q;
  logic                     in_oor;
  logic [CONV_W-1:0]        conv_prod_q;
  logic [RPM_W-1:0]         conv_a;
  logic [RPM_W-1:0]         speed_q;
  logic [TIME_W-1:0]        dt_q;
  logic [LIM_NUM_W-1:0]     lim_prod_q;
  logic [LIM_FULL_W-1:0]    lim_full;
  logic [LIM_W-1:0]         lim_q;
  logic [RPM_W-1:0]         target_q;
  act_t                     act_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [ALPHA_W-1:0]       alpha_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [FAN_CHANNELS-1:0]  warm_q;

  logic                     res_valid;
  logic [RPM_W-1:0]         res_rpm;
  logic [CH_FIELD_W-1:0]    res_ch;

  logic                     ram_we;
  logic [MEM_W-1:0]         ram_rdata;
  logic [RPM_W-1:0]         rd_speed;
  logic [TIME_W-1:0]        rd_time;

  logic                     conv_busy;
  logic [CONV_W-1:0]        conv_quo;
  logic                     alpha_busy;
  logic [ALPHA_NUM_W-1:0]   alpha_quo;
  logic [ALPHA_DEN_W-1:0]   alpha_den;

  logic [CONV_W-1:0]        conv_val;
  logic [RPM_W-1:0]         target;
  logic [RPM_W-1:0]         thr;
  act_t                     act;

  logic signed [STEP_W-1:0] step_raw;
  logic signed [STEP_W-1:0] step_nz;
  logic signed [STEP_W-1:0] step_cl;
  logic signed [STEP_W-1:0] lim_pos;
  logic signed [STEP_W-1:0] lim_neg;
  logic [LIM_W-1:0]         lim_eff;
  logic [RPM_W-1:0]         lag_speed;
  logic [RPM_W-1:0]         new_speed;

  assign addr       = CH_W'(ch_q);
  assign in_oor     = {2'b00, reading.fan_index} >= CH_COUNT;
  assign acc        = reading.valid && reading.ready;
  assign out_free   = !res_valid || result.ready;
  assign div_done   = !conv_busy && !alpha_busy;

  // Sequencer.
  always_comb begin
    state_next    = state;
    reading.ready = 1'b0;
    div_start     = 1'b0;
    fin_go        = 1'b0;
    case (state)
      S_IDLE: begin
        reading.ready = 1'b1;
        if (reading.valid) begin
          state_next = in_oor ? S_FIN : S_READ;
        end
      end
      S_READ:  state_next = S_START;
      S_START: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL:  state_next = S_MUL;
      S_MUL:   state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          fin_go     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-channel state: speed in the upper bits, last update time below.
  fanlag_ram #(
    .WIDTH (MEM_W),
    .DEPTH (FAN_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({new_speed, now_q}),
    .re    (acc),
    .raddr (CH_W'(reading.fan_index)),
    .rdata (ram_rdata)
  );

  assign rd_speed = ram_rdata[MEM_W-1:TIME_W];
  assign rd_time  = ram_rdata[TIME_W-1:0];

  // Conversion divider: max_rpm * raw / steps. The gain divider runs alongside
  // on the gap even when the lag path ends up unused.
  assign alpha_den = {1'b0, lag_tau} + ALPHA_DEN_W'(dt_q[DT_W-1:0]);

  fanlag_div #(
    .NUM_W (CONV_W),
    .DEN_W (STEPS_W)
  ) u_conv_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (conv_prod_q),
    .den   (steps),
    .busy  (conv_busy),
    .quo   (conv_quo)
  );

  fanlag_div #(
    .NUM_W (ALPHA_NUM_W),
    .DEN_W (ALPHA_DEN_W)
  ) u_alpha_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({dt_q[DT_W-1:0], {G{1'b0}}}),
    .den   (alpha_den),
    .busy  (alpha_busy),
    .quo   (alpha_quo)
  );

  assign conv_a   = (steps != '0) ? max_rpm : RPM_W'(raw_mult);
  assign lim_full = LIM_FULL_W'(lim_prod_q) * LIM_FULL_W'(RECIP_MULT);

  // Evaluation of the clamped reading and the case it falls into.
  always_comb begin
    conv_val = (steps != '0) ? conv_quo : conv_prod_q;
    target   = (conv_val > CONV_W'(max_rpm)) ? max_rpm : conv_val[RPM_W-1:0];
    thr      = (stop_thr < THRESHOLD_FLOOR) ? THRESHOLD_FLOOR : stop_thr;
    if (target < thr) begin
      act = ACT_ZERO;
    end else if (!warm_q[addr] || dt_q > STALE_GAP_MS) begin
      act = ACT_JUMP;
    end else if (dt_q < MIN_GAP_MS) begin
      act = ACT_HOLD;
    end else if (target == speed_q) begin
      act = ACT_TIME;
    end else begin
      act = ACT_LAG;
    end
  end

  // Lag step, anti-stall and slew clamp.
  always_comb begin
    step_raw = STEP_W'(prod_q >>> G);
    if (step_raw == '0) begin
      step_nz = delta_q[DELTA_W-1] ? STEP_MINUS_ONE : STEP_ONE;
    end else begin
      step_nz = step_raw;
    end
    lim_eff = (lim_q == '0) ? LIM_W'(1) : lim_q;
    lim_pos = $signed({1'b0, lim_eff});
    lim_neg = -lim_pos;
    if (step_nz > lim_pos) begin
      step_cl = lim_pos;
    end else if (step_nz < lim_neg) begin
      step_cl = lim_neg;
    end else begin
      step_cl = step_nz;
    end
    lag_speed = RPM_W'($signed({{(STEP_W-RPM_W){1'b0}}, speed_q}) + step_cl);
    case (act_q)
      ACT_ZERO: new_speed = '0;
      ACT_JUMP: new_speed = target_q;
      ACT_LAG:  new_speed = lag_speed;
      default:  new_speed = speed_q;
    endcase
  end

  assign ram_we = fin_go && !oor_q && (act_q != ACT_HOLD);

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          ch_q  <= reading.fan_index;
          raw_q <= reading.raw_reading;
          now_q <= reading.time_ms;
          oor_q <= in_oor;
          act_q <= ACT_HOLD;
        end
      end
      S_READ: begin
        speed_q     <= rd_speed;
        dt_q        <= now_q - rd_time;
        conv_prod_q <= CONV_W'(conv_a) * CONV_W'(raw_q);
      end
      S_START: begin
        lim_prod_q <= LIM_NUM_W'(max_slew) * LIM_NUM_W'(dt_q[DT_W-1:0]);
      end
      S_DIV: begin
        lim_q <= lim_full[RECIP_SHIFT +: LIM_W];
      end
      S_EVAL: begin
        target_q <= target;
        act_q    <= act;
        delta_q  <= $signed({1'b0, target}) - $signed({1'b0, speed_q});
        alpha_q  <= alpha_quo[ALPHA_W-1:0];
      end
      S_MUL: begin
        prod_q <= PROD_W'(delta_q) * $signed(PROD_W'(alpha_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_q <= '0;
    end else if (ram_we) begin
      warm_q[addr] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_go) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_rpm <= oor_q ? '0 : new_speed;
      res_ch  <= ch_q;
    end
  end

  assign result.valid          = res_valid;
  assign result.filtered_rpm   = res_rpm;
  assign result.fan_index_echo = res_ch;

`ifndef SYNTH
  // Both dividers must have finished before the case is evaluated.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> !conv_busy && !alpha_busy)
    else $error("evaluation started while a divider was busy");

  // An accepted reading either goes to the RAM read or straight to the result.
  assert property (@(posedge clk) disable iff (rst)
    acc |=> state == S_READ || state == S_FIN)
    else $error("sequencer left the accept path");

  // A write-back always leaves its channel warm.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> warm_q[addr])
    else $error("written channel not marked warm");

  // A result is only produced when the result register can take it.
  assert property (@(posedge clk) disable iff (rst)
    fin_go |-> !res_valid || result.ready)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
